FILE: rtl/mavg_pkg.sv
package mavg_pkg;

  // default sizes
  localparam int WINDOW_MAX_DEF   = 256;
  localparam int SAMPLE_WIDTH_DEF = 32;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 17;

  // group record counter saturates here
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = 13'd8191;

  // q1.16 one and alpha reset value
  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] ALPHA_RESET = 17'd32768;

  // dividend width of the divider
  localparam int NUM_W = 64;

  // register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MODE   = 3'd0,
    REG_WINDOW = 3'd1,
    REG_SKIP   = 3'd2,
    REG_STRICT = 3'd3,
    REG_ALPHA  = 3'd4
  } cfg_reg_t;

  // mode codes, anything from exponential up smooths
  localparam logic [1:0] MODE_SIMPLE   = 2'd0;
  localparam logic [1:0] MODE_WEIGHTED = 2'd1;
  localparam logic [1:0] MODE_EXP      = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_RETIRE,
    S_ACCUM,
    S_EXP,
    S_DSTART,
    S_DWAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic accept;
    logic addr;
    logic retire;
    logic accum;
    logic exp_upd;
    logic div_start;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic use_div;
    logic out_free;
    logic div_done;
  } sts_t;

endpackage

FILE: rtl/mavg_div.sv
module mavg_div #(
  parameter int DVW = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mavg_pkg::NUM_W-1:0]   dividend,
  input  logic [DVW-1:0]               divisor,
  output logic                         done,
  output logic [mavg_pkg::NUM_W-1:0]   quotient
);

  localparam int NW = mavg_pkg::NUM_W;
  localparam int CNTW = $clog2(NW);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   q_r;
  logic [DVW:0]    rem_r;
  logic [DVW-1:0]  dvs_r;
  logic [DVW:0]    sh_c;
  logic            fit_c;

  // one quotient bit per cycle, restoring
  assign sh_c  = {rem_r[DVW-1:0], q_r[NW-1]};
  assign fit_c = sh_c >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fit_c ? (sh_c - {1'b0, dvs_r}) : sh_c;
        q_r   <= {q_r[NW-2:0], fit_c};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/mavg_dp.sv
module mavg_dp #(
  parameter int WINDOW_MAX   = mavg_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = mavg_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mavg_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mavg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic [SAMPLE_WIDTH-1:0]           in_sample,
  input  logic                              in_null,
  input  logic                              in_gs,
  input  mavg_pkg::cmd_t                    cmd,
  output mavg_pkg::sts_t                    sts,
  output logic [SAMPLE_WIDTH-1:0]           out_avg,
  output logic                              out_null,
  output logic                              out_valid,
  input  logic                              out_ready
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CW   = $clog2(WINDOW_MAX + 1);
  localparam int PW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUMW = SW + CW + 1;
  localparam int DVW  = 2 * CW;
  localparam int NW   = mavg_pkg::NUM_W;
  localparam int PRW  = SW + 18;
  localparam int CW_C = mavg_pkg::COUNT_W;

  // configuration registers
  logic [1:0]  mode_r;
  logic [8:0]  wlen_r;
  logic [11:0] skip_r;
  logic        strict_r;
  logic [16:0] alpha_r;

  // item and filter state
  logic signed [SW-1:0]   x_r;
  logic                   null_r;
  logic [WINDOW_MAX-1:0]  valid_r;
  logic [PW-1:0]          pos_r;
  logic [PW-1:0]          p_r;
  logic [CW-1:0]          term_r;
  logic signed [SUMW-1:0] wsum_r;
  logic [NW-1:0]          wtsum_r;
  logic [CW-1:0]          vc_r;
  logic [CW_C-1:0]        rc_r;
  logic signed [SW-1:0]   sm_r;
  logic                   smnull_r;
  logic                   saw_r;
  logic signed [PRW-1:0]  pa_r;
  logic signed [PRW-1:0]  pb_r;
  logic [DVW-1:0]         tri_r;
  logic [NW-1:0]          num_r;
  logic                   neg_r;
  logic [DVW-1:0]         dvs_r;

  // ring memory: null flag over sample
  logic [SW:0] mem [WINDOW_MAX];
  logic [SW:0] rd_r;
  logic        rd_valid_r;

  // output register
  logic          out_valid_r;
  logic [SW-1:0] out_avg_r;
  logic          out_null_r;

  logic [CW-1:0]          term_c;
  logic [PW-1:0]          p_c;
  logic signed [SW-1:0]   stored_c;
  logic                   old_ok_c;
  logic signed [SUMW:0]   wprod_c;
  logic [DVW+1:0]         trip_c;
  logic [16:0]            a_c;
  logic signed [PRW:0]    mix_c;
  logic signed [PRW:0]    adj_c;
  logic [NW-1:0]          num_c;
  logic                   ok_c;
  logic                   div_done;
  logic [NW-1:0]          quot;
  logic [NW-1:0]          sq_c;

  // effective window length
  always_comb begin
    if (wlen_r == 9'd0) begin
      term_c = CW'(1);
    end else if (32'(wlen_r) > 32'(WINDOW_MAX)) begin
      term_c = CW'(WINDOW_MAX);
    end else begin
      term_c = CW'(wlen_r);
    end
  end

  assign p_c      = (CW'(pos_r) >= term_c) ? '0 : pos_r;
  assign stored_c = null_r ? '0 : x_r;
  assign old_ok_c = rd_valid_r & ~rd_r[SW];
  assign wprod_c  = $signed(stored_c) * $signed({1'b0, vc_r});
  assign trip_c   = ({1'b0, {(CW+1){1'b0}}, vc_r} * ({1'b0, {(CW+1){1'b0}}, vc_r} + 1'b1));
  assign a_c      = (alpha_r > mavg_pkg::ONE_Q16) ? mavg_pkg::ONE_Q16 : alpha_r;
  assign mix_c    = {pa_r[PRW-1], pa_r} + {pb_r[PRW-1], pb_r};
  assign adj_c    = mix_c[PRW] ? (mix_c + (PRW+1)'(65535)) : mix_c;
  assign num_c    = (mode_r == mavg_pkg::MODE_SIMPLE) ? NW'(wsum_r) : wtsum_r;
  assign ok_c     = strict_r ? (vc_r == term_r) : (vc_r != '0);
  assign sq_c     = neg_r ? (~quot + 1'b1) : quot;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mavg_pkg::MODE_SIMPLE;
      wlen_r   <= 9'd1;
      skip_r   <= '0;
      strict_r <= 1'b0;
      alpha_r  <= mavg_pkg::ALPHA_RESET;
    end else if (cfg_we) begin
      case (mavg_pkg::cfg_reg_t'(cfg_addr))
        mavg_pkg::REG_MODE:   mode_r   <= cfg_wdata[1:0];
        mavg_pkg::REG_WINDOW: wlen_r   <= cfg_wdata[8:0];
        mavg_pkg::REG_SKIP:   skip_r   <= cfg_wdata[11:0];
        mavg_pkg::REG_STRICT: strict_r <= cfg_wdata[0];
        mavg_pkg::REG_ALPHA:  alpha_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // filter state update, one step per command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      pos_r    <= '0;
      wsum_r   <= '0;
      wtsum_r  <= '0;
      vc_r     <= '0;
      rc_r     <= '0;
      sm_r     <= '0;
      smnull_r <= 1'b1;
      saw_r    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (in_gs) begin
          valid_r  <= '0;
          pos_r    <= '0;
          wsum_r   <= '0;
          wtsum_r  <= '0;
          vc_r     <= '0;
          rc_r     <= CW_C'(1);
          sm_r     <= '0;
          smnull_r <= 1'b1;
          saw_r    <= 1'b0;
        end else if (rc_r < mavg_pkg::COUNT_LIMIT) begin
          rc_r <= rc_r + 1'b1;
        end
      end
      // retire the overwritten entry and count the new one
      if (cmd.retire) begin
        valid_r[p_r] <= 1'b1;
        if (old_ok_c) begin
          wtsum_r <= wtsum_r - NW'(wsum_r);
          wsum_r  <= wsum_r - SUMW'($signed(rd_r[SW-1:0]));
          vc_r    <= (vc_r != '0 ? vc_r - 1'b1 : vc_r) + {{(CW-1){1'b0}}, ~null_r};
        end else begin
          vc_r <= vc_r + {{(CW-1){1'b0}}, ~null_r};
        end
        pos_r <= ((CW'(p_r) + 1'b1) >= term_r) ? '0 : p_r + 1'b1;
      end
      if (cmd.accum) begin
        wtsum_r <= wtsum_r + NW'(wprod_c);
        wsum_r  <= wsum_r + SUMW'(stored_c);
        saw_r   <= saw_r | null_r;
      end
      // exponential smoothing
      if (cmd.exp_upd) begin
        if (strict_r && saw_r) begin
          smnull_r <= 1'b1;
          sm_r     <= '0;
        end else if (!null_r) begin
          smnull_r <= 1'b0;
          sm_r     <= smnull_r ? x_r : SW'(adj_c >>> 16);
        end
      end
    end
  end

  // payload pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r    <= in_sample;
      null_r <= in_null;
    end
    if (cmd.addr) begin
      term_r <= term_c;
      p_r    <= p_c;
    end
    if (cmd.accum) begin
      tri_r <= DVW'(trip_c >> 1);
      pa_r  <= $signed({1'b0, a_c}) * x_r;
      pb_r  <= $signed({1'b0, mavg_pkg::ONE_Q16 - a_c}) * sm_r;
    end
    // signed division reduced to magnitudes
    if (cmd.exp_upd) begin
      neg_r <= num_c[NW-1];
      num_r <= num_c[NW-1] ? (~num_c + 1'b1) : num_c;
      dvs_r <= (mode_r == mavg_pkg::MODE_SIMPLE) ? DVW'(vc_r) : tri_r;
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      rd_r       <= mem[p_c];
      rd_valid_r <= valid_r[p_c];
    end
    if (cmd.retire) begin
      mem[p_r] <= {null_r, stored_c};
    end
  end

  mavg_div #(.DVW(DVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (quot)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (mode_r >= mavg_pkg::MODE_EXP) begin
        out_null_r <= smnull_r;
        out_avg_r  <= smnull_r ? '0 : sm_r;
      end else if (sts.use_div) begin
        out_null_r <= 1'b0;
        out_avg_r  <= sq_c[SW-1:0];
      end else begin
        out_null_r <= 1'b1;
        out_avg_r  <= '0;
      end
    end
  end

  assign sts.skip     = {{(CW_C-12){1'b0}}, skip_r} >= rc_r;
  assign sts.use_div  = (mode_r < mavg_pkg::MODE_EXP) && ok_c && (vc_r != '0);
  assign sts.out_free = ~out_valid_r | out_ready;
  assign sts.div_done = div_done;

  assign out_valid = out_valid_r;
  assign out_avg   = out_avg_r;
  assign out_null  = out_null_r;

  // a null result always carries zero
  a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_null_r) |-> (out_avg_r == '0))
    else $error("null result with nonzero average");

  // valid count never exceeds the ring
  a_vc_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(vc_r) <= WINDOW_MAX)
    else $error("valid count out of range");

  // divider is never done right after a start
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !div_done)
    else $error("divider done right after start");

endmodule

FILE: rtl/mavg_ctrl.sv
module mavg_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mavg_pkg::sts_t sts,
  output mavg_pkg::cmd_t cmd
);

  mavg_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mavg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mavg_pkg::S_IDLE:   if (in_valid) state_nxt = mavg_pkg::S_ADDR;
      mavg_pkg::S_ADDR:   state_nxt = mavg_pkg::S_RETIRE;
      mavg_pkg::S_RETIRE: state_nxt = mavg_pkg::S_ACCUM;
      mavg_pkg::S_ACCUM:  state_nxt = mavg_pkg::S_EXP;
      mavg_pkg::S_EXP: begin
        if (sts.skip) begin
          state_nxt = mavg_pkg::S_IDLE;
        end else if (sts.use_div) begin
          state_nxt = mavg_pkg::S_DSTART;
        end else begin
          state_nxt = mavg_pkg::S_OUT;
        end
      end
      mavg_pkg::S_DSTART: state_nxt = mavg_pkg::S_DWAIT;
      mavg_pkg::S_DWAIT:  if (sts.div_done) state_nxt = mavg_pkg::S_OUT;
      mavg_pkg::S_OUT:    if (sts.out_free) state_nxt = mavg_pkg::S_IDLE;
      default:            state_nxt = mavg_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      mavg_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      mavg_pkg::S_ADDR:   cmd.addr      = 1'b1;
      mavg_pkg::S_RETIRE: cmd.retire    = 1'b1;
      mavg_pkg::S_ACCUM:  cmd.accum     = 1'b1;
      mavg_pkg::S_EXP:    cmd.exp_upd   = 1'b1;
      mavg_pkg::S_DSTART: cmd.div_start = 1'b1;
      mavg_pkg::S_OUT:    cmd.load      = sts.out_free;
      default: ;
    endcase
  end

  // result loads only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> sts.out_free)
    else $error("output register overwritten");

  // divider completion only expected while waiting for it
  a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == mavg_pkg::S_DWAIT))
    else $error("divider done outside wait");

  // one datapath step at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("overlapping commands");

endmodule

FILE: rtl/moving_average_filter.sv
// flow: accept, address, retire, accumulate and exponential steps, then, unless
//   skipped, an optional division and the output load; a new word is taken only
//   after the last one is skipped or loaded, and a division waits on the one-bit divider
// reset: rst_n synchronous active low; control, config and filter registers
//   return to defaults, the ring reads as empty through cleared per-entry valid bits
module moving_average_filter #(
  parameter int WINDOW_MAX   = mavg_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_WIDTH = mavg_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mavg_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mavg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   in_tdata,   // sample
  input  logic [1:0]                          in_tuser,   // sample_is_null, group_start
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   out_tdata,  // average
  output logic [0:0]                          out_tuser   // average_is_null
);

  localparam int DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  mavg_pkg::cmd_t cmd;
  mavg_pkg::sts_t sts;
  logic [SAMPLE_WIDTH-1:0] avg;
  logic                    avg_null;

  mavg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mavg_dp #(
    .WINDOW_MAX   (WINDOW_MAX),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_sample (in_tdata[SAMPLE_WIDTH-1:0]),
    .in_null   (in_tuser[0]),
    .in_gs     (in_tuser[1]),
    .cmd       (cmd),
    .sts       (sts),
    .out_avg   (avg),
    .out_null  (avg_null),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  assign out_tdata = DW'(avg);
  assign out_tuser = avg_null;

endmodule
